/* rtl/core/lcd_4bit_write_sequencer_core_defines.svh */
// Assertion macros for the LCD 4-bit write sequencer.
`ifndef LCD_4BIT_WRITE_SEQUENCER_CORE_DEFINES_SVH
`define LCD_4BIT_WRITE_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LCD4_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LCD4_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define LCD4_ASSERT_IMPL(lbl, prop, msg)
`define LCD4_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

/* rtl/core/lcd4_pkg.sv */
// Types and constants shared by the LCD 4-bit write sequencer.
package lcd4_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RD_SETUP = 4'd1,
        PH_RD1_HIGH = 4'd2,
        PH_RD1_LOW  = 4'd3,
        PH_RD2_SET  = 4'd4,
        PH_RD2_HIGH = 4'd5,
        PH_RD2_HOLD = 4'd6,
        PH_WAIT     = 4'd7,
        PH_W1_SET   = 4'd8,
        PH_W1_HIGH  = 4'd9,
        PH_W1_HOLD  = 4'd10,
        PH_W2_SET   = 4'd11,
        PH_W2_HIGH  = 4'd12,
        PH_W2_HOLD  = 4'd13
    } phase_t;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_WAIT  = 1'd1;
    localparam logic [7:0]  PHASE_TICKS_RST = 8'd1;
    localparam logic [15:0] FIXED_WAIT_RST  = 16'd10000;

    typedef struct packed {
        logic       start_req;
        logic [7:0] byte_value;
        logic       is_data;
        logic       poll_busy;
        logic       full_byte;
        logic       busy_pin;
    } lcd_in_t;

    typedef struct packed {
        logic       rs_pin;
        logic       rw_pin;
        logic       enable_pin;
        logic [3:0] nibble_out;
        logic       drive_bus;
        logic       ready_res;
    } lcd_out_t;

    typedef struct packed {
        logic [7:0]  phase_ticks;
        logic [15:0] fixed_wait_ticks;
    } lcd_cfg_t;

    typedef struct packed {
        logic       rs;
        logic       rw;
        logic       e;
        logic [3:0] nib;
        logic       drive;
    } pins_t;

    typedef struct packed {
        logic is_data;
        logic poll_busy;
        logic full_byte;
    } flags_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] held_byte;
        flags_t     held_flags;
        logic       busy_seen;
        pins_t      pins;
    } lcd_ctl_t;

endpackage

/* rtl/core/lcd4_cfg_regs.sv */
// Configuration registers for phase length and fixed wait.
module lcd4_cfg_regs
    import lcd4_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output lcd_cfg_t              cfg
);

    logic [7:0]  phase_ticks_reg;
    logic [15:0] fixed_wait_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            fixed_wait_reg  <= FIXED_WAIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS: phase_ticks_reg <= cfg_data[7:0];
                CFG_FIXED_WAIT:  fixed_wait_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign cfg.phase_ticks      = phase_ticks_reg;
    assign cfg.fixed_wait_ticks = fixed_wait_reg;

endmodule

/* rtl/core/lcd4_step.sv */
// Next-state and pin logic for one tick of the sequencer.
module lcd4_step
    import lcd4_pkg::*;
#(
    parameter int WAIT_WIDTH = 16
)
(
    input  lcd_cfg_t              cfg,
    input  lcd_in_t               in_item,
    input  lcd_ctl_t              ctl,
    input  logic [WAIT_WIDTH-1:0] tick_count,
    output lcd_ctl_t              ctl_next,
    output logic [WAIT_WIDTH-1:0] tick_next,
    output lcd_out_t              result
);

    localparam logic [31:0] WAIT_MAX = 32'((64'd1 << WAIT_WIDTH) - 64'd1);
    localparam logic [WAIT_WIDTH-1:0] TICK_ONE = WAIT_WIDTH'(1);

    logic [7:0]            pt;
    logic [WAIT_WIDTH-1:0] pt_ticks;
    logic [31:0]           wait_wide;
    logic [WAIT_WIDTH-1:0] wait_ticks;
    logic                  go;
    phase_t                target;
    phase_t                follow;

    assign pt        = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
    assign pt_ticks  = WAIT_WIDTH'(pt);
    assign wait_wide = {16'd0, cfg.fixed_wait_ticks};
    assign wait_ticks = (wait_wide > WAIT_MAX) ? WAIT_MAX[WAIT_WIDTH-1:0]
                                               : wait_wide[WAIT_WIDTH-1:0];

    always_comb
    begin
        case (ctl.phase)
            PH_RD_SETUP: follow = PH_RD1_HIGH;
            PH_RD1_HIGH: follow = PH_RD1_LOW;
            PH_RD1_LOW:  follow = PH_RD2_SET;
            PH_RD2_SET:  follow = PH_RD2_HIGH;
            PH_RD2_HIGH: follow = PH_RD2_HOLD;
            PH_RD2_HOLD: follow = ctl.busy_seen ? PH_RD1_HIGH : PH_W1_SET;
            PH_WAIT:     follow = PH_W1_SET;
            PH_W1_SET:   follow = PH_W1_HIGH;
            PH_W1_HIGH:  follow = PH_W1_HOLD;
            PH_W1_HOLD:  follow = ctl.held_flags.full_byte ? PH_W2_SET : PH_IDLE;
            PH_W2_SET:   follow = PH_W2_HIGH;
            PH_W2_HIGH:  follow = PH_W2_HOLD;
            default:     follow = PH_IDLE;
        endcase
    end

    always_comb
    begin
        ctl_next  = ctl;
        tick_next = tick_count;
        go        = 1'b0;
        target    = PH_IDLE;

        if (ctl.phase == PH_IDLE)
        begin
            if (in_item.start_req)
            begin
                ctl_next.held_byte            = in_item.byte_value;
                ctl_next.held_flags.is_data   = in_item.is_data;
                ctl_next.held_flags.poll_busy = in_item.poll_busy;
                ctl_next.held_flags.full_byte = in_item.full_byte;
                ctl_next.busy_seen            = 1'b0;
                go     = 1'b1;
                target = in_item.poll_busy ? PH_RD_SETUP : PH_WAIT;
            end
        end
        else
        begin
            if (ctl.phase == PH_RD1_HIGH && tick_count <= TICK_ONE)
            begin
                ctl_next.busy_seen = in_item.busy_pin;
            end
            if (tick_count > TICK_ONE)
            begin
                tick_next = tick_count - TICK_ONE;
            end
            else
            begin
                go     = 1'b1;
                target = follow;
            end
        end

        if (go)
        begin
            // zero fixed wait goes straight to the first nibble
            if (target == PH_WAIT && wait_ticks == '0)
            begin
                target = PH_W1_SET;
            end
            ctl_next.phase = target;
            tick_next      = pt_ticks;
            case (target)
                PH_RD_SETUP:
                begin
                    ctl_next.pins = '{rs: 1'b0, rw: 1'b1, e: 1'b0, nib: 4'd0, drive: 1'b0};
                end
                PH_RD1_HIGH, PH_RD2_HIGH, PH_W1_HIGH, PH_W2_HIGH:
                begin
                    ctl_next.pins.e = 1'b1;
                end
                PH_RD1_LOW, PH_RD2_SET, PH_RD2_HOLD, PH_W1_HOLD, PH_W2_HOLD:
                begin
                    ctl_next.pins.e = 1'b0;
                end
                PH_WAIT:
                begin
                    tick_next = wait_ticks;
                end
                PH_W1_SET:
                begin
                    ctl_next.pins = '{rs: ctl_next.held_flags.is_data, rw: 1'b0, e: 1'b0,
                                      nib: ctl_next.held_byte[7:4], drive: 1'b1};
                end
                PH_W2_SET:
                begin
                    ctl_next.pins = '{rs: ctl_next.held_flags.is_data, rw: 1'b0, e: 1'b0,
                                      nib: ctl_next.held_byte[3:0], drive: 1'b1};
                end
                default:
                begin
                    ctl_next.phase  = PH_IDLE;
                    tick_next       = '0;
                    ctl_next.pins.e = 1'b0;
                end
            endcase
        end
    end

    assign result.rs_pin     = ctl.pins.rs;
    assign result.rw_pin     = ctl.pins.rw;
    assign result.enable_pin = ctl.pins.e;
    assign result.nibble_out = ctl.pins.drive ? ctl.pins.nib : 4'd0;
    assign result.drive_bus  = ctl.pins.drive;
    assign result.ready_res  = (ctl.phase == PH_IDLE);

endmodule

/* rtl/core/lcd_4bit_write_sequencer_core.sv */
// Top level of the LCD 4-bit write sequencer: state, result register and checks.
//
// Each request is one time tick of the display interface. The block takes one request
// per clock cycle while the output is not stalled and returns one result per request,
// in the cycle after acceptance, from an output register; a new request is taken in the
// same cycle as a waiting result is taken. The result carries the pin levels in force
// during that tick (before the tick's update) and the ready flag. This rate is set by
// the combinational update of the phase sequencer and its tick counter.
// Configuration writes take effect from the next phase; write only while idle.
`include "lcd_4bit_write_sequencer_core_defines.svh"

module lcd_4bit_write_sequencer_core
    import lcd4_pkg::*;
#(
    parameter int WAIT_WIDTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lcd_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lcd_out_t              out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lcd_cfg_t              cfg;
    lcd_ctl_t              ctl_reg;
    lcd_ctl_t              ctl_next;
    logic [WAIT_WIDTH-1:0] tick_reg;
    logic [WAIT_WIDTH-1:0] tick_next;
    lcd_out_t              result;
    lcd_out_t              out_data_reg;
    logic                  out_valid_reg;
    logic                  accept;

    lcd4_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcd4_step #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_step (
        .cfg        (cfg),
        .in_item    (in_data),
        .ctl        (ctl_reg),
        .tick_count (tick_reg),
        .ctl_next   (ctl_next),
        .tick_next  (tick_next),
        .result     (result)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase      <= PH_IDLE;
            ctl_reg.held_byte  <= 8'd0;
            ctl_reg.held_flags <= '0;
            ctl_reg.busy_seen  <= 1'b0;
            ctl_reg.pins       <= '{rs: 1'b0, rw: 1'b0, e: 1'b0, nib: 4'd0, drive: 1'b1};
            tick_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else if (accept)
        begin
            ctl_reg       <= ctl_next;
            tick_reg      <= tick_next;
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LCD4_ASSERT_NEXT(a_start_leaves_idle,
        accept && in_data.start_req && ctl_reg.phase == PH_IDLE,
        ctl_reg.phase != PH_IDLE, "request taken while idle did not start a sequence")
    `LCD4_ASSERT_IMPL(a_enable_in_high_phase,
        !ctl_reg.pins.e || ctl_reg.phase == PH_RD1_HIGH || ctl_reg.phase == PH_RD2_HIGH ||
        ctl_reg.phase == PH_W1_HIGH || ctl_reg.phase == PH_W2_HIGH,
        "enable high outside a high phase")
    `LCD4_ASSERT_IMPL(a_bus_released_only_reading,
        ctl_reg.pins.drive || ctl_reg.phase == PH_RD_SETUP || ctl_reg.phase == PH_RD1_HIGH ||
        ctl_reg.phase == PH_RD1_LOW || ctl_reg.phase == PH_RD2_SET ||
        ctl_reg.phase == PH_RD2_HIGH || ctl_reg.phase == PH_RD2_HOLD,
        "bus released outside a busy poll")
    `LCD4_ASSERT_IMPL(a_tick_nonzero_when_active,
        ctl_reg.phase == PH_IDLE || tick_reg != '0, "active phase with zero tick count")

endmodule

/* test/lcd_4bit_write_sequencer_core_tb.sv */
// Testbench for the LCD 4-bit write sequencer: tick-by-tick pin prediction and checking.
`timescale 1ns / 100ps

module lcd_4bit_write_sequencer_core_tb
    import lcd4_pkg::*;
;

    localparam int QUIET_LIMIT = 2000;

    class lcd_pin_tracker;
        phase_t       ph;
        logic [15:0]  ticks_left;
        logic [7:0]   held;
        flags_t       flags;
        logic         busy_seen;
        pins_t        pins;
        logic [7:0]   enable_ticks;
        logic [15:0]  wait_ticks;
        lcd_out_t     pins_due[$];
        int           fails;

        function new();
            enable_ticks = PHASE_TICKS_RST;
            wait_ticks   = FIXED_WAIT_RST;
            ph           = PH_IDLE;
            ticks_left   = '0;
            held         = '0;
            flags        = '0;
            busy_seen    = 1'b0;
            pins         = '{rs: 1'b0, rw: 1'b0, e: 1'b0, nib: 4'd0, drive: 1'b1};
            fails        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_PHASE_TICKS)
                enable_ticks = d[7:0];
            else if (idx == CFG_FIXED_WAIT)
                wait_ticks = d;
        endfunction

        function bit at_rest();
            return ph == PH_IDLE;
        endfunction

        function int pending();
            return pins_due.size();
        endfunction

        function phase_t after_phase(phase_t p);
            case (p)
                PH_RD_SETUP: return PH_RD1_HIGH;
                PH_RD1_HIGH: return PH_RD1_LOW;
                PH_RD1_LOW:  return PH_RD2_SET;
                PH_RD2_SET:  return PH_RD2_HIGH;
                PH_RD2_HIGH: return PH_RD2_HOLD;
                PH_RD2_HOLD: return busy_seen ? PH_RD1_HIGH : PH_W1_SET;
                PH_WAIT:     return PH_W1_SET;
                PH_W1_SET:   return PH_W1_HIGH;
                PH_W1_HIGH:  return PH_W1_HOLD;
                PH_W1_HOLD:  return flags.full_byte ? PH_W2_SET : PH_IDLE;
                PH_W2_SET:   return PH_W2_HIGH;
                PH_W2_HIGH:  return PH_W2_HOLD;
                default:     return PH_IDLE;
            endcase
        endfunction

        function void start_phase(phase_t p);
            logic [7:0] pt;
            pt = (enable_ticks == 8'd0) ? 8'd1 : enable_ticks;
            // zero wait goes straight to the first nibble
            if (p == PH_WAIT && wait_ticks == 16'd0)
                p = PH_W1_SET;
            ph = p;
            ticks_left = {8'd0, pt};
            case (p)
                PH_RD_SETUP:
                    pins = '{rs: 1'b0, rw: 1'b1, e: 1'b0, nib: 4'd0, drive: 1'b0};
                PH_RD1_HIGH, PH_RD2_HIGH, PH_W1_HIGH, PH_W2_HIGH:
                    pins.e = 1'b1;
                PH_RD1_LOW, PH_RD2_SET, PH_RD2_HOLD, PH_W1_HOLD, PH_W2_HOLD:
                    pins.e = 1'b0;
                PH_WAIT:
                    ticks_left = wait_ticks;
                PH_W1_SET:
                    pins = '{rs: flags.is_data, rw: 1'b0, e: 1'b0, nib: held[7:4], drive: 1'b1};
                PH_W2_SET:
                    pins = '{rs: flags.is_data, rw: 1'b0, e: 1'b0, nib: held[3:0], drive: 1'b1};
                default:
                begin
                    ph = PH_IDLE;
                    ticks_left = '0;
                    pins.e = 1'b0;
                end
            endcase
        endfunction

        function void take_tick(lcd_in_t t);
            lcd_out_t due;
            logic     idle_now;
            idle_now       = (ph == PH_IDLE) || (ph > PH_W2_HOLD);
            due.rs_pin     = pins.rs;
            due.rw_pin     = pins.rw;
            due.enable_pin = pins.e;
            due.nibble_out = pins.drive ? pins.nib : 4'd0;
            due.drive_bus  = pins.drive;
            due.ready_res  = idle_now;
            pins_due.push_back(due);
            if (idle_now)
            begin
                ph = PH_IDLE;
                if (t.start_req)
                begin
                    held            = t.byte_value;
                    flags.is_data   = t.is_data;
                    flags.poll_busy = t.poll_busy;
                    flags.full_byte = t.full_byte;
                    busy_seen       = 1'b0;
                    start_phase(t.poll_busy ? PH_RD_SETUP : PH_WAIT);
                end
                return;
            end
            // busy is sampled on the last tick of the first E-high
            if (ph == PH_RD1_HIGH && ticks_left <= 16'd1)
                busy_seen = t.busy_pin;
            if (ticks_left > 16'd1)
                ticks_left--;
            else
                start_phase(after_phase(ph));
        endfunction

        function void field_ok(string name, logic [3:0] want, logic [3:0] seen);
            if (want !== seen)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                fails++;
            end
        endfunction

        function void check_pins(lcd_out_t got);
            lcd_out_t due;
            if (pins_due.size() == 0)
            begin
                $error("pin result with no request outstanding");
                fails++;
                return;
            end
            due = pins_due.pop_front();
            field_ok("rs_pin", 4'(due.rs_pin), 4'(got.rs_pin));
            field_ok("rw_pin", 4'(due.rw_pin), 4'(got.rw_pin));
            field_ok("enable_pin", 4'(due.enable_pin), 4'(got.enable_pin));
            field_ok("nibble_out", due.nibble_out, got.nibble_out);
            field_ok("drive_bus", 4'(due.drive_bus), 4'(got.drive_bus));
            field_ok("ready_res", 4'(due.ready_res), 4'(got.ready_res));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    lcd_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    lcd_out_t              out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PHASE_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit                    gaps_on = 1'b1;
    int                    quiet_cycles = 0;
    lcd_pin_tracker        tracker = new();

    lcd_4bit_write_sequencer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_pins(out_data);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic lcd_in_t random_tick(int busy_pct);
        logic [31:0] r;
        lcd_in_t     t;
        r = $urandom;
        t = r[$bits(lcd_in_t)-1:0];
        t.busy_pin = ($urandom_range(0, 99) < busy_pct);
        if (tracker.at_rest())
            t.start_req = ($urandom_range(0, 4) != 0);
        return t;
    endfunction

    task automatic send_tick(input lcd_in_t t);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (!in_ready);
        tracker.take_tick(t);
    endtask

    task automatic issue_write(input logic [7:0] b, input logic dat, input logic poll,
                               input logic full, input int busy_pct);
        lcd_in_t t;
        t = random_tick(busy_pct);
        t.start_req  = 1'b1;
        t.byte_value = b;
        t.is_data    = dat;
        t.poll_busy  = poll;
        t.full_byte  = full;
        send_tick(t);
        while (!tracker.at_rest())
            send_tick(random_tick(busy_pct));
    endtask

    task automatic load_regs(input logic [7:0] pt, input logic [7:0] pt_pad,
                             input logic [15:0] wt);
        lcd_in_t t;
        while (!tracker.at_rest())
        begin
            t = random_tick(0);
            t.start_req = 1'b0;
            send_tick(t);
        end
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= {pt_pad, pt};
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(CFG_PHASE_TICKS, {pt_pad, pt});
        cfg_index <= CFG_FIXED_WAIT;
        cfg_data  <= wt;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(CFG_FIXED_WAIT, wt);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] pt;
        int         busy_pct;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        issue_write(8'hA5, 1'b1, 1'b1, 1'b1, 0);
        issue_write(8'h00, 1'b0, 1'b1, 1'b1, 0);
        issue_write(8'hFF, 1'b1, 1'b1, 1'b0, 60);

        // zero enable phase and zero wait
        load_regs(8'd0, 8'h00, 16'd0);
        issue_write(8'h3C, 1'b0, 1'b0, 1'b1, 0);
        issue_write(8'hC3, 1'b1, 1'b0, 1'b0, 0);
        issue_write(8'h5A, 1'b1, 1'b1, 1'b1, 70);
        issue_write(8'hFF, 1'b0, 1'b1, 1'b1, 0);

        load_regs(8'd255, 8'hFF, 16'd5);
        issue_write(8'h81, 1'b1, 1'b0, 1'b0, 0);

        load_regs(8'd2, 8'h5A, 16'd1);
        issue_write(8'h96, 1'b1, 1'b0, 1'b1, 30);
        issue_write(8'h69, 1'b0, 1'b1, 1'b0, 30);

        for (int k = 0; k < 6; k++)
        begin
            if (k == 5)
                gaps_on = 1'b0;
            if (k == 0)
                pt = 8'd1;
            else if (k == 3)
                pt = 8'($urandom_range(5, 12));
            else
                pt = 8'($urandom_range(1, 4));
            load_regs(pt, 8'($urandom), 16'($urandom_range(0, 24)));
            busy_pct = $urandom_range(15, 60);
            repeat (170) send_tick(random_tick(busy_pct));
        end

        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
